// ----- hdl/b64e_pkg.sv -----
package b64e_pkg;

   localparam int unsigned QDepth   = 2;
   localparam int unsigned QPtrBits = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int unsigned QCntBits = $clog2(QDepth + 1);

   localparam logic [6:0] PadIndex = 7'd64;

   // byte counts within a group
   localparam logic [1:0] PhaseStart = 2'd0;
   localparam logic [1:0] PhaseOne   = 2'd1;
   localparam logic [1:0] PhaseTwo   = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       group_end;
      logic       message_end;
   } rsp_type;

   // one run of four output characters, built from one to three bytes
   typedef struct packed {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [1:0] count;
      logic       msg_end;
   } run_type;

   // front to queue handshake
   typedef struct packed {
      logic    push;
      run_type run;
   } q_wr_type;

   // queue to back status
   typedef struct packed {
      logic    valid;
      run_type run;
   } q_rd_type;

   // alphabet index (0..63, 64 for pad) of character k of a run
   function automatic logic [6:0] b64e_index(run_type r, logic [1:0] k);
      logic [6:0] idx;
      idx = PadIndex;
      case (k)
         2'd0: idx = {3'b000, r.byte_a[7:4]} << 2 | {5'd0, r.byte_a[3:2]};
         2'd1: idx = {1'b0, r.byte_a[1:0],
                      (r.count > 2'd1) ? r.byte_b[7:4] : 4'h0};
         2'd2: idx = (r.count > 2'd1) ?
                     {1'b0, r.byte_b[3:0], (r.count > 2'd2) ? r.byte_c[7:6] : 2'b00} :
                     PadIndex;
         2'd3: idx = (r.count > 2'd2) ? {1'b0, r.byte_c[5:0]} : PadIndex;
         default: idx = PadIndex;
      endcase
      return idx;
   endfunction

   // standard alphabet, pad '=' at index 64
   function automatic logic [7:0] b64e_char(logic [6:0] idx);
      logic [7:0] c;
      c = 8'h3D;
      case (idx) inside
         [7'd0:7'd25]:  c = 8'h41 + {1'b0, idx};
         [7'd26:7'd51]: c = 8'h61 + {1'b0, idx - 7'd26};
         [7'd52:7'd61]: c = 8'h30 + {1'b0, idx - 7'd52};
         7'd62:         c = 8'h2B;
         7'd63:         c = 8'h2F;
         default:       c = 8'h3D;
      endcase
      return c;
   endfunction

endpackage

// ----- hdl/b64e_front.sv -----
module b64e_front
   import b64e_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_item,
   input  logic     q_full,
   output q_wr_type q_wr
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  phase_ff, phase_in;
   logic        accept;
   logic [1:0]  phase;

   assign full   = q_full;
   assign accept = push & ~q_full;

   always_comb begin
      phase       = (phase_ff == 2'd3) ? PhaseStart : phase_ff;
      held_in     = held_ff;
      phase_in    = phase_ff;
      q_wr.push   = 1'b0;
      q_wr.run    = '0;
      if (accept) begin
         case (phase)
            PhaseTwo: begin
               q_wr.push        = 1'b1;
               q_wr.run.byte_a  = held_ff[15:8];
               q_wr.run.byte_b  = held_ff[7:0];
               q_wr.run.byte_c  = req_item.in_byte;
               q_wr.run.count   = 2'd3;
               q_wr.run.msg_end = req_item.last_byte;
               held_in          = '0;
               phase_in         = PhaseStart;
            end
            PhaseOne: begin
               if (req_item.last_byte) begin
                  q_wr.push        = 1'b1;
                  q_wr.run.byte_a  = held_ff[7:0];
                  q_wr.run.byte_b  = req_item.in_byte;
                  q_wr.run.count   = 2'd2;
                  q_wr.run.msg_end = 1'b1;
                  held_in          = '0;
                  phase_in         = PhaseStart;
               end else begin
                  held_in  = {held_ff[7:0], req_item.in_byte};
                  phase_in = PhaseTwo;
               end
            end
            default: begin
               if (req_item.last_byte) begin
                  q_wr.push        = 1'b1;
                  q_wr.run.byte_a  = req_item.in_byte;
                  q_wr.run.count   = 2'd1;
                  q_wr.run.msg_end = 1'b1;
                  held_in          = '0;
                  phase_in         = PhaseStart;
               end else begin
                  held_in  = {8'h00, req_item.in_byte};
                  phase_in = PhaseOne;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         phase_ff <= PhaseStart;
      end else begin
         held_ff  <= held_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- hdl/b64e_queue.sv -----
module b64e_queue
   import b64e_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  q_wr_type q_wr,
   output logic     q_full,
   output q_rd_type q_rd,
   input  logic     q_pop
);

   run_type              entry_ff [QDepth];
   logic [QPtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCntBits-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_full     = (count_ff == QCntBits'(QDepth));
   assign q_rd.valid = (count_ff != '0);
   assign q_rd.run   = entry_ff[rd_ptr_ff];

   assign do_push = q_wr.push & ~q_full;
   assign do_pop  = q_pop & q_rd.valid;

   function automatic logic [QPtrBits-1:0] next_ptr(logic [QPtrBits-1:0] p);
      return (p == QPtrBits'(QDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCntBits'(do_push) - QCntBits'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_wr.run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/b64e_back.sv -----
module b64e_back
   import b64e_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  q_rd_type q_rd,
   output logic     q_pop,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_item
);

   run_type    run_ff, run_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance, run_done;

   assign advance  = busy_ff & (~out_valid_ff | pop);
   assign run_done = advance & (idx_ff == 2'd3);
   assign q_pop    = q_rd.valid & (~busy_ff | run_done);

   always_comb begin
      run_in       = run_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~pop;
      if (advance) begin
         out_in.out_char    = b64e_char(b64e_index(run_ff, idx_ff));
         out_in.group_end   = (idx_ff == 2'd3);
         out_in.message_end = (idx_ff == 2'd3) & run_ff.msg_end;
         out_valid_in       = 1'b1;
         idx_in             = idx_ff + 2'd1;
         if (run_done) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         run_in  = q_rd.run;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty    = ~out_valid_ff;
   assign rsp_item = out_ff;

endmodule

// ----- hdl/base64_stream_encoder_core.sv -----
// Base64 stream encoder, standard alphabet with '=' padding.
// Request side is a queue write port: present a byte on req_item with push
// high; the transaction completes on a clock edge where full is low. Flag the
// final byte of a message with last_byte.
// Response side is a queue read port: while empty is low, rsp_item holds the
// oldest character; pop completes the transaction at a clock edge.
// Every group of three bytes (or the final partial group) makes a run of four
// characters; group_end marks the fourth, message_end also marks it on the
// final run of a message.
// The byte that completes a run is written into the queue as it is accepted;
// the serializer then loads the run and registers its first character.
// Throughput: one character per cycle out of a single output register when
// the reader pops every cycle; each three bytes make four characters. A
// two-run queue sits between the byte grouper and the character serializer,
// so bytes keep flowing while a run is being emitted.
// Reset (synchronous, active high) drops any held bytes, empties the queue
// and the output register; the next byte starts a new message.
// When the reader stalls, the output holds, the queue fills, and full rises.
module base64_stream_encoder_core
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full;
   logic     q_pop;

   // front: groups bytes, decides when a run is complete
   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .q_full   (q_full),
      .q_wr     (q_wr)
   );

   // short run queue decoupling grouping from serialization
   b64e_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   // back: one character per cycle into the output register while the reader pops
   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_rd     (q_rd),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ----- hdl/b64e_checker.sv -----
module b64e_checker
   import b64e_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_item
);

   // nothing to read right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("output not empty after reset");

   // room for input right after reset
   a_reset_room: assert property (@(posedge clock) reset |=> !full)
      else $error("full after reset");

   // end of message only on the last character of a run
   a_msg_end_group: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.message_end) |-> rsp_item.group_end)
      else $error("message_end without group_end");

   // only alphabet characters or pad leave the block
   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      !empty |->
         ((rsp_item.out_char >= 8'h41) && (rsp_item.out_char <= 8'h5A)) ||
         ((rsp_item.out_char >= 8'h61) && (rsp_item.out_char <= 8'h7A)) ||
         ((rsp_item.out_char >= 8'h30) && (rsp_item.out_char <= 8'h39)) ||
         (rsp_item.out_char == 8'h2B) || (rsp_item.out_char == 8'h2F) ||
         (rsp_item.out_char == 8'h3D))
      else $error("illegal output character");

   // a waiting transaction holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("response changed while stalled");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
